>>> rtl/hioc_pkg.sv
package hioc_pkg;

    localparam int BUCKETS_DEF     = 1024;
    localparam int CHAIN_SLOTS_DEF = 4096;

    localparam int ID_W   = 64;
    localparam int DATA_W = 32;
    localparam int PERM_W = 32;
    localparam int FLAG_W = 64;
    localparam int LINK_W = 13;
    localparam int SLOT_W = 13;

    localparam logic ST_INSERTED = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [DATA_W-1:0] data;
        logic [FLAG_W-1:0] flag_word;
        logic [PERM_W-1:0] perm;
        logic [LINK_W-1:0] link;
    } entry_t;

endpackage

>>> rtl/hioc_entry_ram.sv
module hioc_entry_ram
    import hioc_pkg::*;
#(
    parameter int DEPTH = BUCKETS_DEF + CHAIN_SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  entry_t                   wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output entry_t                   rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hioc_walk_ctrl.sv
module hioc_walk_ctrl
    import hioc_pkg::*;
#(
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int CHAIN_SLOTS = CHAIN_SLOTS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic [ID_W-1:0]                            id_high,
    input  logic [ID_W-1:0]                            id_low,
    input  logic [DATA_W-1:0]                          data_offset,
    input  logic [PERM_W-1:0]                          perm_mask,
    input  logic [FLAG_W-1:0]                          entry_flags,
    output logic                                       done,
    output logic                                       status,
    output logic [SLOT_W-1:0]                          slot_index,
    output logic                                       ram_we,
    output logic [$clog2(BUCKETS + CHAIN_SLOTS)-1:0]   ram_waddr,
    output entry_t                                     ram_wdata,
    output logic                                       ram_re,
    output logic [$clog2(BUCKETS + CHAIN_SLOTS)-1:0]   ram_raddr,
    input  entry_t                                     ram_rdata
);

    localparam int TS = BUCKETS + CHAIN_SLOTS;
    localparam int AW = $clog2(TS);
    localparam int PW = $clog2(TS + 1);
    localparam int IW = $clog2(TS + 2);
    localparam int BW = $clog2(BUCKETS);
    localparam int CW = (LINK_W > PW) ? LINK_W : PW;

    localparam logic [PW-1:0] PTR_END   = PW'(TS);
    localparam logic [PW-1:0] PTR_LAST  = PW'(TS - 1);
    localparam logic [PW-1:0] PTR_FIRST = PW'(BUCKETS);
    localparam logic [IW-1:0] ITER_MAX  = IW'(TS + 1);
    localparam logic [CW-1:0] LINK_END  = CW'(TS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RELOAD = 3'd4;

    logic [2:0]        state_reg,  state_next;
    logic [AW-1:0]     cur_reg,    cur_next;
    logic [PW-1:0]     ptr_reg,    ptr_next;
    logic [IW-1:0]     iter_reg,   iter_next;
    logic              done_reg,   done_next;
    logic              status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg,   slot_next;
    entry_t            in_reg,     in_next;
    entry_t            hold_reg,   hold_next;

    logic          rd_empty;
    logic          rd_free;
    logic          link_ok;
    logic [PW-1:0] ptr_inc;
    logic [AW-1:0] home;

    // shared compare unit on the entry just read
    assign rd_empty = (ram_rdata.id_high == '0) && (ram_rdata.id_low == '0);
    assign rd_free  = rd_empty && (ram_rdata.link == '0);
    assign link_ok  = (ram_rdata.link != '0) && (CW'(ram_rdata.link) < LINK_END);
    assign ptr_inc  = ptr_reg + 1'b1;
    assign home     = AW'(id_low[BW-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        ptr_next    = ptr_reg;
        iter_next   = iter_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        in_next     = in_reg;
        hold_next   = hold_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg;
        ram_wdata   = in_reg;
        ram_re      = 1'b0;
        ram_raddr   = cur_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(ptr_reg);
                ram_wdata = '0;
                if (ptr_reg == PTR_LAST)
                begin
                    ptr_next   = PTR_FIRST;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    in_next.id_high   = id_high;
                    in_next.id_low    = id_low;
                    in_next.data      = data_offset;
                    in_next.flag_word = entry_flags;
                    in_next.perm      = perm_mask;
                    in_next.link      = '0;
                    cur_next          = home;
                    iter_next         = '0;
                    ram_re            = 1'b1;
                    ram_raddr         = home;
                    state_next        = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (iter_reg == ITER_MAX)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    slot_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                    if (rd_empty)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = in_reg;
                        ram_wdata.link = ram_rdata.link;
                        done_next      = 1'b1;
                        status_next    = ST_INSERTED;
                        slot_next      = SLOT_W'(cur_reg);
                        state_next     = S_IDLE;
                    end
                    else if (link_ok)
                    begin
                        cur_next  = AW'(ram_rdata.link);
                        ram_re    = 1'b1;
                        ram_raddr = AW'(ram_rdata.link);
                    end
                    else
                    begin
                        hold_next = ram_rdata;
                        if (ptr_reg == PTR_END)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            slot_next   = '0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(ptr_reg);
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // overflow slots never become free again, so the scan resumes at ptr
                if (rd_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = hold_reg;
                    ram_wdata.link = LINK_W'(ptr_reg);
                    cur_next       = AW'(ptr_reg);
                    state_next     = S_RELOAD;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    if (ptr_inc == PTR_END)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        slot_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(ptr_inc);
                    end
                end
            end
            S_RELOAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cur_reg;
                state_next = S_LOOK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cur_reg    <= '0;
            ptr_reg    <= '0;
            iter_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_INSERTED;
            slot_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            ptr_reg    <= ptr_next;
            iter_reg   <= iter_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        hold_reg <= hold_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

endmodule

>>> rtl/hash_insert_overflow_chain_core.sv
// Inserts one entry per start transaction into a table of BUCKETS home slots followed by
// CHAIN_SLOTS overflow slots, held in one single-port-read entry RAM. After reset a clearing
// pass writes every slot to zero with busy high. An insert is accepted when start is high and
// busy is low; the result is presented on status and slot_index for exactly one cycle with
// done high, and busy is already low in that cycle. The receiver cannot stall the result, so
// capture it when done is high. An insert walks the chain with one RAM read per slot visited;
// if no slot on the chain is empty, it scans overflow slots for a free one, links it to the
// chain tail and reads it again before writing the entry, and the result is registered. The
// scan resumes where the previous one stopped, so its cost is shared out over all inserts.
// BUCKETS must be a power of two.
module hash_insert_overflow_chain_core
    import hioc_pkg::*;
#(
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int CHAIN_SLOTS = CHAIN_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ID_W-1:0]   id_high,
    input  logic [ID_W-1:0]   id_low,
    input  logic [DATA_W-1:0] data_offset,
    input  logic [PERM_W-1:0] perm_mask,
    input  logic [FLAG_W-1:0] entry_flags,
    output logic              done,
    output logic              status,
    output logic [SLOT_W-1:0] slot_index
);

    localparam int TS = BUCKETS + CHAIN_SLOTS;
    localparam int AW = $clog2(TS);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    hioc_walk_ctrl #(
        .BUCKETS     (BUCKETS),
        .CHAIN_SLOTS (CHAIN_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .id_high     (id_high),
        .id_low      (id_low),
        .data_offset (data_offset),
        .perm_mask   (perm_mask),
        .entry_flags (entry_flags),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    hioc_entry_ram #(
        .DEPTH (TS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> dv/tb_hash_insert_overflow_chain_core.sv
module tb_hash_insert_overflow_chain_core;
    import hioc_pkg::*;

    localparam int TABLE_DEPTH  = BUCKETS_DEF + CHAIN_SLOTS_DEF;
    localparam int HOME_W       = $clog2(BUCKETS_DEF);
    localparam int QUIET_LIMIT  = 50000;
    localparam int RANDOM_ITEMS = 734;
    localparam int REPORT_LIMIT = 10;
    localparam int HOT_HOMES    = 6;

    typedef struct packed {
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [DATA_W-1:0] data_offset;
        logic [PERM_W-1:0] perm_mask;
        logic [FLAG_W-1:0] entry_flags;
    } insert_req_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
    } placement_t;

    class perm_table_tracker;
        // only ids and links steer placement
        logic [ID_W-1:0]   owner_hi  [TABLE_DEPTH];
        logic [ID_W-1:0]   owner_lo  [TABLE_DEPTH];
        logic [LINK_W-1:0] next_slot [TABLE_DEPTH];
        placement_t        pending_q [$];
        int                failures;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                owner_hi[i]  = '0;
                owner_lo[i]  = '0;
                next_slot[i] = '0;
            end
            failures = 0;
        endfunction

        function bit vacant(int i);
            return owner_hi[i] == '0 && owner_lo[i] == '0;
        endfunction

        function placement_t place_entry(insert_req_t r);
            placement_t o;
            int         cur;
            int         nxt;
            int         free_slot;
            int         steps;
            o.status = ST_FULL;
            o.slot   = '0;
            cur      = int'({r.id_high, r.id_low} % BUCKETS_DEF);
            steps    = 0;
            while (steps <= TABLE_DEPTH)
            begin
                steps++;
                if (vacant(cur))
                begin
                    owner_hi[cur] = r.id_high;
                    owner_lo[cur] = r.id_low;
                    o.status      = ST_INSERTED;
                    o.slot        = SLOT_W'(cur);
                    return o;
                end
                nxt = int'(next_slot[cur]);
                if (nxt != 0 && nxt < TABLE_DEPTH)
                begin
                    cur = nxt;
                    continue;
                end
                free_slot = 0;
                for (int i = BUCKETS_DEF; i < TABLE_DEPTH; i++)
                begin
                    if (next_slot[i] == '0 && vacant(i))
                    begin
                        free_slot = i;
                        break;
                    end
                end
                if (free_slot == 0)
                    break;
                next_slot[cur] = LINK_W'(free_slot);
                cur            = free_slot;
            end
            return o;
        endfunction

        function void note_insert(insert_req_t r);
            pending_q.push_back(place_entry(r));
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void check_result(logic st, logic [SLOT_W-1:0] slot);
            placement_t e;
            if (pending_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result: status %0b slot %0d", st, slot));
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status || slot !== e.slot)
                note_failure($sformatf("mismatch: expected status %0b slot %0d, got status %0b slot %0d",
                                       e.status, e.slot, st, slot));
        endfunction
    endclass

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    insert_req_t       req   = '0;
    logic              busy;
    logic              done;
    logic              status;
    logic [SLOT_W-1:0] slot_index;

    perm_table_tracker tracker;
    int                burst_left = 1;
    logic [2*ID_W-1:0] recent_ids [$];
    logic [HOME_W-1:0] hot_home [HOT_HOMES];

    hash_insert_overflow_chain_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .id_high     (req.id_high),
        .id_low      (req.id_low),
        .data_offset (req.data_offset),
        .perm_mask   (req.perm_mask),
        .entry_flags (req.entry_flags),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_result(status, slot_index);
            if (start && !busy)
                tracker.note_insert(req);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (done || (start && !busy))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic insert_req_t make_req(logic [ID_W-1:0] hi, logic [ID_W-1:0] lo,
                                             logic [DATA_W-1:0] d, logic [PERM_W-1:0] p,
                                             logic [FLAG_W-1:0] f);
        insert_req_t r;
        r.id_high     = hi;
        r.id_low      = lo;
        r.data_offset = d;
        r.perm_mask   = p;
        r.entry_flags = f;
        return r;
    endfunction

    function automatic insert_req_t random_request();
        logic [2*ID_W-1:0] id;
        int                kind;
        kind = $urandom_range(0, 99);
        id   = {$urandom, $urandom, $urandom, $urandom};
        if (kind < 45)
            id[HOME_W-1:0] = hot_home[$urandom_range(0, HOT_HOMES - 1)];
        else if (kind < 57 && recent_ids.size() != 0)
            id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else if (kind < 62)
            id = '0;
        else if (kind < 67)
            id[ID_W-1:0] = '0;
        else if (kind < 70)
            id[2*ID_W-1:ID_W] = '0;
        recent_ids.push_back(id);
        if (recent_ids.size() > 16)
            void'(recent_ids.pop_front());
        return make_req(id[2*ID_W-1:ID_W], id[ID_W-1:0], DATA_W'(pick_word()),
                        PERM_W'(pick_word()), pick_word());
    endfunction

    task automatic push_insert(input insert_req_t r);
        int gap;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic run_directed();
        // zero id stays empty, duplicates chain, scan reuses a linked zero-id slot
        push_insert(make_req('0, '0, '0, '0, '0));
        push_insert(make_req('0, '0, '1, '1, '1));
        push_insert(make_req('1, 64'hFFFF_FFFF_FFFF_FC00, '1, '1, '1));
        push_insert(make_req('1, 64'hFFFF_FFFF_FFFF_FC00, '0, '1, '0));
        push_insert(make_req('0, '0, 32'h1234_5678, 32'h8000_0001, 64'h1));
        push_insert(make_req('0, 64'd7, '1, '0, '1));
        push_insert(make_req(64'd1, 64'd7, 32'hAAAA_AAAA, 32'h5555_5555, '1));
        push_insert(make_req('1, '1, '1, '1, '1));
        push_insert(make_req('1, '1, '0, '0, '0));
        push_insert(make_req('0, 64'd1, 32'h5555_5555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555));
        push_insert(make_req(64'h8000_0000_0000_0000, '0, '1, '1, 64'h8000_0000_0000_0000));
        push_insert(make_req(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                             '0, '1, 64'hAAAA_AAAA_AAAA_AAAA));
        push_insert(make_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                             '1, '0, 64'h5555_5555_5555_5555));
        push_insert(make_req('0, 64'h400, 32'd1, 32'd1, 64'd2));
        push_insert(make_req('0, '0, '0, '0, '0));
        push_insert(make_req(64'd3, 64'd7, '1, '1, '0));
    endtask

    task automatic run_random();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            push_insert(random_request());
    endtask

    initial
    begin
        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        hot_home[0] = '0;
        hot_home[1] = '1;
        for (int i = 2; i < HOT_HOMES; i++)
            hot_home[i] = HOME_W'($urandom);
        run_directed();
        run_random();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
